[hw/rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, action and status codes, and the controller command
// bundle for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int ACTION_W    = 3;
   localparam int WORD_W      = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

[hw/rtl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: capture a transaction, run one store access, present the
// result until it is taken.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output deq_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign cmd.load  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec  = (state_ff == ST_EXEC);

endmodule

[hw/rtl/deq_dpath.sv]
// ----------------------------------------------------------------------------
// deq_dpath
// Circular store with front index and entry count; one read or write per
// transaction, registered read data and result fields.
// ----------------------------------------------------------------------------
module deq_dpath #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  deq_pkg::cmd_type                cmd,
   input  logic [deq_pkg::ACTION_W-1:0]    req_action,
   input  logic [deq_pkg::WORD_W-1:0]      req_data_in,
   output logic [deq_pkg::WORD_W-1:0]      rsp_data_out,
   output logic [deq_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                            rsp_is_empty,
   output logic [deq_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int SW   = CW + 1;
   localparam int WIDE = (DATA_WIDTH > deq_pkg::WORD_W) ? DATA_WIDTH : deq_pkg::WORD_W;
   localparam int OW   = (CW > deq_pkg::COUNT_OUT_W) ? CW : deq_pkg::COUNT_OUT_W;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [deq_pkg::ACTION_W-1:0] action_ff;
   logic [DATA_WIDTH-1:0]        word_ff;
   logic [AW-1:0]                front_ff;
   logic [AW-1:0]                front_in;
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic [DATA_WIDTH-1:0]        rd_ff;
   logic                         pop_ok_ff;
   logic                         pop_ok_in;
   logic [deq_pkg::STATUS_W-1:0] status_ff;
   logic [deq_pkg::STATUS_W-1:0] status_in;

   logic [WIDE-1:0] wide_in;
   logic [WIDE-1:0] wide_out;
   logic [OW-1:0]   count_wide;
   logic            full;
   logic            empty;
   logic [CW-1:0]   offset;
   logic [SW-1:0]   sum;
   logic [SW-1:0]   sum_wrap;
   logic [AW-1:0]   wrap_addr;
   logic [AW-1:0]   front_dec;
   logic [AW-1:0]   front_inc;
   logic [AW-1:0]   addr;
   logic            write_en;

   assign wide_in = WIDE'(req_data_in);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);

   assign offset    = (action_ff == deq_pkg::ACT_PUSH_BACK) ? count_ff : count_ff - CW'(1);
   assign sum       = SW'(front_ff) + SW'(offset);
   assign sum_wrap  = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
   assign wrap_addr = sum_wrap[AW-1:0];
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = deq_pkg::STATUS_DONE;
      pop_ok_in = 1'b0;
      write_en  = 1'b0;
      addr      = front_ff;
      case (action_ff)
         deq_pkg::ACT_PUSH_FRONT: begin
            addr = front_dec;
            if (full) begin
               status_in = deq_pkg::STATUS_PUSH_FULL;
            end else begin
               write_en = 1'b1;
               front_in = front_dec;
               count_in = count_ff + CW'(1);
            end
         end
         deq_pkg::ACT_PUSH_BACK: begin
            addr = wrap_addr;
            if (full) begin
               status_in = deq_pkg::STATUS_PUSH_FULL;
            end else begin
               write_en = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         deq_pkg::ACT_POP_FRONT: begin
            addr = front_ff;
            if (empty) begin
               status_in = deq_pkg::STATUS_POP_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               front_in  = front_inc;
               count_in  = count_ff - CW'(1);
            end
         end
         deq_pkg::ACT_POP_BACK: begin
            addr = wrap_addr;
            if (empty) begin
               status_in = deq_pkg::STATUS_POP_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               count_in  = count_ff - CW'(1);
            end
         end
         deq_pkg::ACT_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         word_ff   <= wide_in[DATA_WIDTH-1:0];
      end
      if (cmd.exec) begin
         if (write_en) begin
            mem[addr] <= word_ff;
         end
         rd_ff     <= mem[addr];
         pop_ok_ff <= pop_ok_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   assign wide_out        = WIDE'(rd_ff);
   assign count_wide      = OW'(count_ff);
   assign rsp_data_out    = pop_ok_ff ? wide_out[deq_pkg::WORD_W-1:0] : '0;
   assign rsp_entry_count = count_wide[deq_pkg::COUNT_OUT_W-1:0];
   assign rsp_is_empty    = empty;
   assign rsp_status      = status_ff;

endmodule

[hw/rtl/double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of data words in a circular store: push or pop
// at either end, or clear; one result per transaction.
// ----------------------------------------------------------------------------
//  channel | ports  | carries
//  --------+--------+-------------------------------------------------------
//  request | req_*  | action, data_in
//  result  | rsp_*  | data_out, entry_count, is_empty, status
//
//  Each transaction passes through capture, one store access and result;
//  the store has a single port, and the next request is taken once the
//  result has been accepted.
//  Reset empties the queue (front index and count to zero); store contents
//  are not cleared. A stalled result holds all result fields.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [deq_pkg::ACTION_W-1:0]    req_action,
   input  logic [deq_pkg::WORD_W-1:0]      req_data_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [deq_pkg::WORD_W-1:0]      rsp_data_out,
   output logic [deq_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                            rsp_is_empty,
   output logic [deq_pkg::STATUS_W-1:0]    rsp_status
);

   deq_pkg::cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   deq_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_data_in     (req_data_in),
      .rsp_data_out    (rsp_data_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

endmodule

[tb/double_ended_queue_core_test.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_core_test
// Drives pushes, pops, clears and unused action codes into the queue core.
// Directed rows come first: empty and full edges, wrap of the front index,
// and reserved actions. Random traffic follows, leaning toward pushes or pops
// in turns so the count sweeps between empty and full. Every result is
// checked field by field against a typed row's values or a cycle-free store
// model, with random idling on both channels, one long result stall, one drain.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test;

   localparam int DEPTH        = deq_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1100;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int ROW_COUNT    = 18;
   localparam int HOLD_CYCLES  = 60;

   localparam logic [deq_pkg::ACTION_W-1:0] ACT_RESERVED_A = 3'd5;
   localparam logic [deq_pkg::ACTION_W-1:0] ACT_RESERVED_B = 3'd6;
   localparam logic [deq_pkg::ACTION_W-1:0] ACT_RESERVED_C = 3'd7;

   typedef struct packed {
      logic [deq_pkg::WORD_W-1:0]      data_out;
      logic [deq_pkg::COUNT_OUT_W-1:0] entry_count;
      logic                            is_empty;
      logic [deq_pkg::STATUS_W-1:0]    status;
   } deq_result_type;

   typedef struct packed {
      logic [deq_pkg::ACTION_W-1:0] action;
      logic [deq_pkg::WORD_W-1:0]   data;
      int                           reps;
      bit                           typed;
      deq_result_type               want;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [deq_pkg::ACTION_W-1:0]    req_action = deq_pkg::ACT_PUSH_FRONT;
   logic [deq_pkg::WORD_W-1:0]      req_data_in = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [deq_pkg::WORD_W-1:0]      rsp_data_out;
   logic [deq_pkg::COUNT_OUT_W-1:0] rsp_entry_count;
   logic                            rsp_is_empty;
   logic [deq_pkg::STATUS_W-1:0]    rsp_status;

   logic [deq_pkg::WORD_W-1:0]      model_words [DEPTH];
   logic [3:0]                      model_front = '0;
   logic [deq_pkg::COUNT_OUT_W-1:0] model_count = '0;

   deq_result_type expected_results [$];
   deq_result_type oldest;
   int             mismatch_count = 0;
   int             cycle_count = 0;
   bit             quiet = 1'b0;
   bit             hold_request = 1'b0;
   int             hold_left = 0;

   stim_row_type directed_rows [ROW_COUNT] = '{
      '{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 1,  1'b1,
        '{32'h0, 5'd0,  1'b1, deq_pkg::STATUS_POP_EMPTY}},
      '{deq_pkg::ACT_POP_BACK,   32'h0000_0000, 1,  1'b1,
        '{32'h0, 5'd0,  1'b1, deq_pkg::STATUS_POP_EMPTY}},
      '{ACT_RESERVED_C,          32'hFFFF_FFFF, 1,  1'b1,
        '{32'h0, 5'd0,  1'b1, deq_pkg::STATUS_DONE}},
      '{deq_pkg::ACT_CLEAR,      32'hFFFF_FFFF, 1,  1'b1,
        '{32'h0, 5'd0,  1'b1, deq_pkg::STATUS_DONE}},
      '{deq_pkg::ACT_PUSH_BACK,  32'hFFFF_FFFF, 1,  1'b1,
        '{32'h0, 5'd1,  1'b0, deq_pkg::STATUS_DONE}},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h0000_0000, 1,  1'b1,
        '{32'h0, 5'd2,  1'b0, deq_pkg::STATUS_DONE}},
      '{deq_pkg::ACT_PUSH_BACK,  32'h8000_0000, 14, 1'b0, '0},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h1234_5678, 1,  1'b1,
        '{32'h0, 5'd16, 1'b0, deq_pkg::STATUS_PUSH_FULL}},
      '{deq_pkg::ACT_PUSH_BACK,  32'h8765_4321, 1,  1'b1,
        '{32'h0, 5'd16, 1'b0, deq_pkg::STATUS_PUSH_FULL}},
      '{deq_pkg::ACT_POP_BACK,   32'h0000_0000, 1,  1'b0, '0},
      '{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 1,  1'b0, '0},
      '{ACT_RESERVED_A,          32'hA5A5_A5A5, 1,  1'b0, '0},
      '{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 1,  1'b0, '0},
      '{ACT_RESERVED_B,          32'h5A5A_5A5A, 1,  1'b0, '0},
      '{deq_pkg::ACT_CLEAR,      32'h0000_0000, 1,  1'b1,
        '{32'h0, 5'd0,  1'b1, deq_pkg::STATUS_DONE}},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h0F0F_0F0F, 1,  1'b0, '0},
      '{deq_pkg::ACT_POP_BACK,   32'h0000_0000, 1,  1'b0, '0},
      '{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 1,  1'b1,
        '{32'h0, 5'd0,  1'b1, deq_pkg::STATUS_POP_EMPTY}}
   };

   double_ended_queue_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_out    (rsp_data_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic deq_result_type apply_action(
         input logic [deq_pkg::ACTION_W-1:0] act,
         input logic [deq_pkg::WORD_W-1:0]   word);
      deq_result_type r;
      logic [3:0]     slot;
      r = '0;
      r.status = deq_pkg::STATUS_DONE;
      case (act)
         deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
            if (model_count == DEPTH) begin
               r.status = deq_pkg::STATUS_PUSH_FULL;
            end else if (act == deq_pkg::ACT_PUSH_FRONT) begin
               model_front = model_front - 4'd1;
               model_words[model_front] = word;
               model_count = model_count + 5'd1;
            end else begin
               slot = model_front + model_count[3:0];
               model_words[slot] = word;
               model_count = model_count + 5'd1;
            end
         end
         deq_pkg::ACT_POP_FRONT: begin
            if (model_count == 0) begin
               r.status = deq_pkg::STATUS_POP_EMPTY;
            end else begin
               r.data_out = model_words[model_front];
               model_front = model_front + 4'd1;
               model_count = model_count - 5'd1;
            end
         end
         deq_pkg::ACT_POP_BACK: begin
            if (model_count == 0) begin
               r.status = deq_pkg::STATUS_POP_EMPTY;
            end else begin
               slot = model_front + model_count[3:0] - 4'd1;
               r.data_out = model_words[slot];
               model_count = model_count - 5'd1;
            end
         end
         deq_pkg::ACT_CLEAR: begin
            model_front = '0;
            model_count = '0;
         end
         default: begin
         end
      endcase
      r.entry_count = model_count;
      r.is_empty = (model_count == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string field,
                                  input logic [deq_pkg::WORD_W-1:0] got,
                                  input logic [deq_pkg::WORD_W-1:0] want);
      mismatch_count++;
      $display("mismatch on %s at cycle %0d: got %h, want %h",
               field, cycle_count, got, want);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer(input logic [deq_pkg::ACTION_W-1:0] act,
                        input logic [deq_pkg::WORD_W-1:0] word,
                        input bit typed, input deq_result_type want);
      deq_result_type predicted;
      if (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_data_in <= word;
      do @(posedge clock); while (!req_ready);
      predicted = apply_action(act, word);
      expected_results.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= 7);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_data_out, '0);
         end else begin
            oldest = expected_results.pop_front();
            if (rsp_data_out !== oldest.data_out)
               report_mismatch("data_out", rsp_data_out, oldest.data_out);
            if (rsp_entry_count !== oldest.entry_count)
               report_mismatch("entry_count", deq_pkg::WORD_W'(rsp_entry_count),
                               deq_pkg::WORD_W'(oldest.entry_count));
            if (rsp_is_empty !== oldest.is_empty)
               report_mismatch("is_empty", deq_pkg::WORD_W'(rsp_is_empty),
                               deq_pkg::WORD_W'(oldest.is_empty));
            if (rsp_status !== oldest.status)
               report_mismatch("status", deq_pkg::WORD_W'(rsp_status),
                               deq_pkg::WORD_W'(oldest.status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [deq_pkg::ACTION_W-1:0] act;
      int                           lean;
      int                           push_share;
      int                           pick;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         for (int k = 0; k < directed_rows[i].reps; k++) begin
            offer(directed_rows[i].action, directed_rows[i].data + k,
                  directed_rows[i].typed, directed_rows[i].want);
         end
      end

      lean = 2;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 400 && n < 600);
         if (n == 200) begin
            hold_request = 1'b1;
         end
         if (n == 700) begin
            req_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge clock);
            @(negedge clock);
         end
         if (n % 48 == 0) begin
            lean = $urandom_range(2);
         end
         push_share = (lean == 0) ? 75 : (lean == 1) ? 25 : 50;
         pick = $urandom_range(99);
         if (pick < 1) begin
            act = deq_pkg::ACT_CLEAR;
         end else if (pick < 3) begin
            act = deq_pkg::ACTION_W'($urandom_range(ACT_RESERVED_C, ACT_RESERVED_A));
         end else if ($urandom_range(99) < push_share) begin
            act = $urandom_range(1) ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT;
         end else begin
            act = $urandom_range(1) ? deq_pkg::ACT_POP_BACK : deq_pkg::ACT_POP_FRONT;
         end
         offer(act, $urandom(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/deq_pkg.sv
hw/rtl/deq_ctrl.sv
hw/rtl/deq_dpath.sv
hw/rtl/double_ended_queue_core.sv
tb/double_ended_queue_core_test.sv
